// File: hdl/slc_pkg.sv
// shared types and constants for the supercover line cell generator
`timescale 1ns / 1ps
`default_nettype none

package slc_pkg;

    localparam int FIELD_BITS         = 16;
    localparam int COORD_BITS_DEFAULT = 16;

    typedef enum logic
    {
        OP_START = 1'b0,
        OP_NEXT  = 1'b1
    } op_t;

    typedef struct packed
    {
        logic valid;
        logic last;
    } cell_flags_t;

endpackage

`default_nettype wire

// File: hdl/slc_core.sv
// line tracer state, pending cell store and per-transaction cell step
`timescale 1ns / 1ps
`default_nettype none

module slc_core
    import slc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  advance,
    input  wire op_t                   op,
    input  wire logic [COORD_BITS-1:0] x0,
    input  wire logic [COORD_BITS-1:0] y0,
    input  wire logic [COORD_BITS-1:0] x1,
    input  wire logic [COORD_BITS-1:0] y1,
    output logic      [COORD_BITS-1:0] res_x,
    output logic      [COORD_BITS-1:0] res_y,
    output cell_flags_t                res_flags
);

    localparam int EW = COORD_BITS + 3;

    logic [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0] cur_y_reg, cur_y_next;
    logic [COORD_BITS-1:0] span_x_reg, span_x_next;
    logic [COORD_BITS-1:0] span_y_reg, span_y_next;
    logic                  dxn_reg, dxn_next;
    logic                  dyn_reg, dyn_next;
    logic                  x_major_reg, x_major_next;
    logic [EW-1:0]         err_acc_reg, err_acc_next;
    logic [EW-1:0]         err_prev_reg, err_prev_next;
    logic [COORD_BITS-1:0] steps_reg, steps_next;
    logic [1:0]            pend_cnt_reg, pend_cnt_next;
    logic                  active_reg, active_next;

    logic [COORD_BITS-1:0] pend_x_reg [2];
    logic [COORD_BITS-1:0] pend_y_reg [2];
    logic [COORD_BITS-1:0] pend_x_next [2];
    logic [COORD_BITS-1:0] pend_y_next [2];

    // start decode
    logic                  st_dxn;
    logic                  st_dyn;
    logic [COORD_BITS-1:0] st_sx;
    logic [COORD_BITS-1:0] st_sy;
    logic                  st_xm;
    logic [COORD_BITS-1:0] st_major;

    // step datapath
    logic [COORD_BITS-1:0] major;
    logic [COORD_BITS-1:0] minor;
    logic [EW-1:0]         dmaj;
    logic [EW-1:0]         dmin;
    logic [COORD_BITS-1:0] nx;
    logic [COORD_BITS-1:0] ny;
    logic [COORD_BITS-1:0] stepped_x;
    logic [COORD_BITS-1:0] stepped_y;
    logic [EW-1:0]         acc1;
    logic [EW-1:0]         acc2;
    logic [EW-1:0]         sum_s;
    logic                  corner;
    logic [COORD_BITS-1:0] m_x;
    logic [COORD_BITS-1:0] m_y;
    logic [COORD_BITS-1:0] j_x;
    logic [COORD_BITS-1:0] j_y;
    logic [COORD_BITS-1:0] steps_inc;

    assign st_dxn   = x1 < x0;
    assign st_dyn   = y1 < y0;
    assign st_sx    = st_dxn ? x0 - x1 : x1 - x0;
    assign st_sy    = st_dyn ? y0 - y1 : y1 - y0;
    assign st_xm    = st_sx >= st_sy;
    assign st_major = st_xm ? st_sx : st_sy;

    assign major     = x_major_reg ? span_x_reg : span_y_reg;
    assign minor     = x_major_reg ? span_y_reg : span_x_reg;
    assign dmaj      = EW'({major, 1'b0});
    assign dmin      = EW'({minor, 1'b0});
    assign stepped_x = dxn_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
    assign stepped_y = dyn_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
    assign acc1      = err_acc_reg + dmin;
    assign corner    = acc1 > dmaj;
    assign acc2      = corner ? acc1 - dmaj : acc1;
    assign sum_s     = acc2 + err_prev_reg;
    assign steps_inc = steps_reg + 1'b1;

    // new main cell: major axis always moves, minor axis on a corner crossing
    assign nx = (x_major_reg || corner) ? stepped_x : cur_x_reg;
    assign ny = (!x_major_reg || corner) ? stepped_y : cur_y_reg;

    // side cells behind on the minor and on the major axis
    assign m_x = x_major_reg ? nx : cur_x_reg;
    assign m_y = x_major_reg ? cur_y_reg : ny;
    assign j_x = x_major_reg ? cur_x_reg : nx;
    assign j_y = x_major_reg ? ny : cur_y_reg;

    always_comb
    begin
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        span_x_next    = span_x_reg;
        span_y_next    = span_y_reg;
        dxn_next       = dxn_reg;
        dyn_next       = dyn_reg;
        x_major_next   = x_major_reg;
        err_acc_next   = err_acc_reg;
        err_prev_next  = err_prev_reg;
        steps_next     = steps_reg;
        pend_cnt_next  = pend_cnt_reg;
        active_next    = active_reg;
        pend_x_next[0] = pend_x_reg[0];
        pend_y_next[0] = pend_y_reg[0];
        pend_x_next[1] = pend_x_reg[1];
        pend_y_next[1] = pend_y_reg[1];
        res_x          = '0;
        res_y          = '0;
        res_flags      = '0;

        if (op == OP_START)
        begin
            dxn_next        = st_dxn;
            dyn_next        = st_dyn;
            span_x_next     = st_sx;
            span_y_next     = st_sy;
            x_major_next    = st_xm;
            err_acc_next    = EW'(st_major);
            err_prev_next   = EW'(st_major);
            steps_next      = '0;
            pend_cnt_next   = '0;
            cur_x_next      = x0;
            cur_y_next      = y0;
            res_x           = x0;
            res_y           = y0;
            res_flags.valid = 1'b1;
            res_flags.last  = (st_major == '0);
            active_next     = (st_major != '0);
        end
        else if (!active_reg)
        begin
            res_flags = '0;
        end
        else if (pend_cnt_reg != 2'd0)
        begin
            res_x           = pend_x_reg[0];
            res_y           = pend_y_reg[0];
            pend_x_next[0]  = pend_x_reg[1];
            pend_y_next[0]  = pend_y_reg[1];
            pend_cnt_next   = pend_cnt_reg - 2'd1;
            res_flags.valid = 1'b1;
            res_flags.last  = (pend_cnt_next == 2'd0) && (steps_reg >= major);
            active_next     = !res_flags.last;
        end
        else
        begin
            cur_x_next    = nx;
            cur_y_next    = ny;
            err_acc_next  = acc2;
            err_prev_next = acc2;
            steps_next    = steps_inc;
            if (!corner)
            begin
                res_x         = nx;
                res_y         = ny;
                pend_cnt_next = 2'd0;
            end
            else if (sum_s < dmaj)
            begin
                res_x          = m_x;
                res_y          = m_y;
                pend_x_next[0] = nx;
                pend_y_next[0] = ny;
                pend_cnt_next  = 2'd1;
            end
            else if (sum_s > dmaj)
            begin
                res_x          = j_x;
                res_y          = j_y;
                pend_x_next[0] = nx;
                pend_y_next[0] = ny;
                pend_cnt_next  = 2'd1;
            end
            else
            begin
                // exact corner: both side cells
                res_x          = m_x;
                res_y          = m_y;
                pend_x_next[0] = j_x;
                pend_y_next[0] = j_y;
                pend_x_next[1] = nx;
                pend_y_next[1] = ny;
                pend_cnt_next  = 2'd2;
            end
            res_flags.valid = 1'b1;
            res_flags.last  = (pend_cnt_next == 2'd0) && (steps_inc >= major);
            active_next     = !res_flags.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg    <= '0;
            cur_y_reg    <= '0;
            span_x_reg   <= '0;
            span_y_reg   <= '0;
            dxn_reg      <= 1'b0;
            dyn_reg      <= 1'b0;
            x_major_reg  <= 1'b0;
            err_acc_reg  <= '0;
            err_prev_reg <= '0;
            steps_reg    <= '0;
            pend_cnt_reg <= '0;
            active_reg   <= 1'b0;
        end
        else if (advance)
        begin
            cur_x_reg    <= cur_x_next;
            cur_y_reg    <= cur_y_next;
            span_x_reg   <= span_x_next;
            span_y_reg   <= span_y_next;
            dxn_reg      <= dxn_next;
            dyn_reg      <= dyn_next;
            x_major_reg  <= x_major_next;
            err_acc_reg  <= err_acc_next;
            err_prev_reg <= err_prev_next;
            steps_reg    <= steps_next;
            pend_cnt_reg <= pend_cnt_next;
            active_reg   <= active_next;
        end
    end

    // pending store, no reset
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pend_x_reg[0] <= pend_x_next[0];
            pend_y_reg[0] <= pend_y_next[0];
            pend_x_reg[1] <= pend_x_next[1];
            pend_y_reg[1] <= pend_y_next[1];
        end
    end

`ifndef NO_ASSERTIONS
    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_cnt_reg != 2'd3)
        else $error("pending count out of range");

    a_pend_active: assert property (@(posedge clk) disable iff (!rst_n)
        pend_cnt_reg != 2'd0 |-> active_reg)
        else $error("queued cells without an active line");

    a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> steps_reg <= major)
        else $error("major-axis steps beyond line length");
`endif

endmodule

`default_nettype wire

// File: hdl/supercover_line_cells.sv
// supercover line cell generator top level: input register, tracer core, result register
`timescale 1ns / 1ps
`default_nettype none

// channel   signals                                  direction
// input     in_valid, in_ready, opcode, start_x,      in
//           start_y, end_x, end_y
// output    out_valid, out_ready, cell_x, cell_y,     out
//           cell_valid, last_cell
//
// one transaction per cycle unless the output stalls; each result passes both registers
// the tracer step is two adds, one subtract and three compares on the error term
// reset clears the line state, so a next transaction after reset gives an invalid result
// a stalled output holds its result while one more transaction waits in the input register

module supercover_line_cells
    import slc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  opcode,
    input  wire logic [FIELD_BITS-1:0] start_x,
    input  wire logic [FIELD_BITS-1:0] start_y,
    input  wire logic [FIELD_BITS-1:0] end_x,
    input  wire logic [FIELD_BITS-1:0] end_y,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic      [FIELD_BITS-1:0] cell_x,
    output logic      [FIELD_BITS-1:0] cell_y,
    output logic                       cell_valid,
    output logic                       last_cell
);

    logic                  in_valid_reg;
    op_t                   op_reg;
    logic [COORD_BITS-1:0] x0_reg;
    logic [COORD_BITS-1:0] y0_reg;
    logic [COORD_BITS-1:0] x1_reg;
    logic [COORD_BITS-1:0] y1_reg;

    logic                  out_valid_reg;
    logic [FIELD_BITS-1:0] cell_x_reg;
    logic [FIELD_BITS-1:0] cell_y_reg;
    cell_flags_t           flags_reg;

    logic                  advance;
    logic [COORD_BITS-1:0] core_x;
    logic [COORD_BITS-1:0] core_y;
    cell_flags_t           core_flags;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            op_reg <= op_t'(opcode);
            x0_reg <= COORD_BITS'(start_x);
            y0_reg <= COORD_BITS'(start_y);
            x1_reg <= COORD_BITS'(end_x);
            y1_reg <= COORD_BITS'(end_y);
        end
    end

    slc_core #(
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .op        (op_reg),
        .x0        (x0_reg),
        .y0        (y0_reg),
        .x1        (x1_reg),
        .y1        (y1_reg),
        .res_x     (core_x),
        .res_y     (core_y),
        .res_flags (core_flags)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cell_x_reg <= FIELD_BITS'(core_x);
            cell_y_reg <= FIELD_BITS'(core_y);
            flags_reg  <= core_flags;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cell_x     = cell_x_reg;
    assign cell_y     = cell_y_reg;
    assign cell_valid = flags_reg.valid;
    assign last_cell  = flags_reg.last;

`ifndef NO_ASSERTIONS
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_valid_reg |=> out_valid)
        else $error("held transaction not moved to result register");

    a_start_valid: assert property (@(posedge clk) disable iff (!rst_n)
        advance && op_reg == OP_START |=> out_valid && cell_valid)
        else $error("start transaction gave no cell");

    a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_cell |-> cell_valid)
        else $error("last flag on an invalid result");
`endif

endmodule

`default_nettype wire

// File: tb/supercover_line_cells_tb.sv
// testbench for the supercover line cell generator: scoreboarded cell traces under random flow control
`timescale 1ns / 1ps

module supercover_line_cells_tb;
    import slc_pkg::*;

    localparam int ITEMS_PER_PHASE = 282;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 20;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int MAX_REPORTS     = 100;

    typedef struct packed
    {
        op_t                   op;
        logic [FIELD_BITS-1:0] sx;
        logic [FIELD_BITS-1:0] sy;
        logic [FIELD_BITS-1:0] ex;
        logic [FIELD_BITS-1:0] ey;
    } line_req_t;

    typedef struct packed
    {
        logic [FIELD_BITS-1:0] x;
        logic [FIELD_BITS-1:0] y;
        cell_flags_t           flags;
    } cell_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic                  opcode    = 1'b0;
    logic [FIELD_BITS-1:0] start_x   = '0;
    logic [FIELD_BITS-1:0] start_y   = '0;
    logic [FIELD_BITS-1:0] end_x     = '0;
    logic [FIELD_BITS-1:0] end_y     = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [FIELD_BITS-1:0] cell_x;
    logic [FIELD_BITS-1:0] cell_y;
    logic                  cell_valid;
    logic                  last_cell;

    line_req_t line_q[$];
    cell_t     cell_expected_q[$];
    logic      in_taken       = 1'b0;
    int        accepted_n     = 0;
    int        errors         = 0;
    int        reports        = 0;
    int        cycles         = 0;
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;
    int        hold_req       = 0;
    int        hold_served    = 0;
    int        hold_left      = 0;

    // tracer state
    bit [15:0] cur_x     = '0;
    bit [15:0] cur_y     = '0;
    bit [15:0] span_x    = '0;
    bit [15:0] span_y    = '0;
    bit        dir_xn    = 1'b0;
    bit        dir_yn    = 1'b0;
    bit        x_major   = 1'b0;
    bit        line_on   = 1'b0;
    int        err_acc   = 0;
    int        err_prev  = 0;
    int        steps_done = 0;
    bit [15:0] pend_x[2];
    bit [15:0] pend_y[2];
    int        pend_n    = 0;

    supercover_line_cells DUT
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .cell_x     (cell_x),
        .cell_y     (cell_y),
        .cell_valid (cell_valid),
        .last_cell  (last_cell)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic bit [15:0] step_coord(bit [15:0] v, bit neg, bit back);
        return (neg != back) ? v - 16'd1 : v + 16'd1;
    endfunction

    function automatic bit [15:0] rand_coord();
        return 16'($urandom);
    endfunction

    task automatic queue_req(input line_req_t r);
        line_q.insert(line_q.size(), r);
    endtask

    task automatic close_cell(input bit [15:0] x, input bit [15:0] y, output cell_t res);
        bit [15:0] major;
        major = x_major ? span_x : span_y;
        res = '0;
        res.x = x;
        res.y = y;
        res.flags.valid = 1'b1;
        if (pend_n == 0 && steps_done >= int'(major))
        begin
            res.flags.last = 1'b1;
            line_on = 1'b0;
        end
    endtask

    task automatic predict_cell(input line_req_t req, output cell_t res);
        bit [15:0] cx[3];
        bit [15:0] cy[3];
        bit [15:0] mx, my, jx, jy, px, py;
        bit        minor_neg;
        int        n, dmaj, dmin, s;
        res = '0;
        if (req.op == OP_START)
        begin
            dir_xn = req.ex < req.sx;
            dir_yn = req.ey < req.sy;
            span_x = dir_xn ? req.sx - req.ex : req.ex - req.sx;
            span_y = dir_yn ? req.sy - req.ey : req.ey - req.sy;
            x_major = span_x >= span_y;
            err_acc = int'(x_major ? span_x : span_y);
            err_prev = err_acc;
            steps_done = 0;
            pend_n = 0;
            cur_x = req.sx;
            cur_y = req.sy;
            line_on = 1'b1;
            close_cell(cur_x, cur_y, res);
        end
        else if (!line_on)
        begin
            res = '0;
        end
        else if (pend_n > 0)
        begin
            px = pend_x[0];
            py = pend_y[0];
            pend_x[0] = pend_x[1];
            pend_y[0] = pend_y[1];
            pend_n--;
            close_cell(px, py, res);
        end
        else
        begin
            n = 0;
            dmaj = 2 * int'(x_major ? span_x : span_y);
            dmin = 2 * int'(x_major ? span_y : span_x);
            minor_neg = x_major ? dir_yn : dir_xn;
            if (x_major)
                cur_x = step_coord(cur_x, dir_xn, 1'b0);
            else
                cur_y = step_coord(cur_y, dir_yn, 1'b0);
            err_acc += dmin;
            if (err_acc > dmaj)
            begin
                if (x_major)
                    cur_y = step_coord(cur_y, minor_neg, 1'b0);
                else
                    cur_x = step_coord(cur_x, minor_neg, 1'b0);
                err_acc -= dmaj;
                s = err_acc + err_prev;
                if (x_major)
                begin
                    mx = cur_x;
                    my = step_coord(cur_y, dir_yn, 1'b1);
                    jx = step_coord(cur_x, dir_xn, 1'b1);
                    jy = cur_y;
                end
                else
                begin
                    mx = step_coord(cur_x, dir_xn, 1'b1);
                    my = cur_y;
                    jx = cur_x;
                    jy = step_coord(cur_y, dir_yn, 1'b1);
                end
                // corner crossing gives the m side cell below dmaj, the j side cell above it, both when equal
                if (s <= dmaj)
                begin
                    cx[n] = mx;
                    cy[n] = my;
                    n++;
                end
                if (s >= dmaj)
                begin
                    cx[n] = jx;
                    cy[n] = jy;
                    n++;
                end
            end
            cx[n] = cur_x;
            cy[n] = cur_y;
            n++;
            err_prev = err_acc;
            steps_done++;
            for (int i = 1; i < n; i++)
            begin
                pend_x[i - 1] = cx[i];
                pend_y[i - 1] = cy[i];
            end
            pend_n = n - 1;
            close_cell(cx[0], cy[0], res);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            errors++;
            if (reports < MAX_REPORTS)
            begin
                reports++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            end
        end
    endtask

    task automatic push_line(input bit [15:0] x0, input bit [15:0] y0,
                             input bit [15:0] x1, input bit [15:0] y1, input int nexts);
        queue_req('{op: OP_START, sx: x0, sy: y0, ex: x1, ey: y1});
        for (int i = 0; i < nexts; i++)
        begin
            queue_req('{op: OP_NEXT, sx: rand_coord(), sy: rand_coord(),
                        ex: rand_coord(), ey: rand_coord()});
        end
    endtask

    task automatic add_directed();
        queue_req('{op: OP_NEXT, sx: 16'hFFFF, sy: 16'hFFFF,
                    ex: 16'hFFFF, ey: 16'hFFFF});
        push_line(16'd5, 16'd5, 16'd5, 16'd5, 1);
        push_line(16'd0, 16'd0, 16'd3, 16'd3, 10);
        push_line(16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 2);
        push_line(16'd0, 16'd0, 16'd1, 16'd3, 3);
        push_line(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFF0, 2);
    endtask

    task automatic add_random(input int count);
        int        goal, r, dx, dy, big, tiny;
        bit [15:0] x0, y0, x1, y1;
        goal = line_q.size() + count;
        while (line_q.size() < goal)
        begin
            r  = int'($urandom_range(0, 99));
            x0 = rand_coord();
            y0 = rand_coord();
            dx = int'($urandom_range(0, 12));
            dy = int'($urandom_range(0, 12));
            x1 = $urandom_range(0, 1) ? x0 + 16'(dx) : x0 - 16'(dx);
            y1 = $urandom_range(0, 1) ? y0 + 16'(dy) : y0 - 16'(dy);
            big  = (dx > dy) ? dx : dy;
            tiny = (dx > dy) ? dy : dx;
            if (r < 75)
                push_line(x0, y0, x1, y1, big + tiny + int'($urandom_range(0, 3)));
            else if (r < 85)
                push_line(x0, y0, rand_coord(), rand_coord(), int'($urandom_range(1, 20)));
            else if (r < 95)
                push_line(x0, y0, x1, y1, int'($urandom_range(0, big)));
            else
            begin
                for (int i = int'($urandom_range(1, 3)); i > 0; i--)
                begin
                    queue_req('{op: OP_NEXT, sx: rand_coord(), sy: rand_coord(),
                                ex: rand_coord(), ey: rand_coord()});
                end
            end
        end
    endtask

    task automatic wait_drained();
        do
        begin
            @(posedge clk);
        end
        while (line_q.size() != 0 || in_valid || cell_expected_q.size() != 0);
    endtask

    // sender
    always @(negedge clk)
    begin
        line_req_t req;
        if (rst_n && (!in_valid || in_taken))
        begin
            if (line_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                req = line_q.pop_front();
                in_valid <= 1'b1;
                opcode   <= req.op;
                start_x  <= req.sx;
                start_y  <= req.sy;
                end_x    <= req.ex;
                end_y    <= req.ey;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver, with long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req != hold_served)
        begin
            hold_served = hold_req;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // monitor and scoreboard
    always @(posedge clk)
    begin
        line_req_t req;
        cell_t     want;
        if (!rst_n)
        begin
            in_taken <= 1'b0;
        end
        else
        begin
            in_taken <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                req.op = op_t'(opcode);
                req.sx = start_x;
                req.sy = start_y;
                req.ex = end_x;
                req.ey = end_y;
                predict_cell(req, want);
                cell_expected_q.insert(cell_expected_q.size(), want);
                accepted_n++;
            end
            if (out_valid && out_ready)
            begin
                if (cell_expected_q.size() == 0)
                begin
                    errors++;
                    if (reports < MAX_REPORTS)
                    begin
                        reports++;
                        $display("%0t: unexpected cell transaction, actual x %0h y %0h",
                                 $time, cell_x, cell_y);
                    end
                end
                else
                begin
                    want = cell_expected_q.pop_front();
                    check_field("cell_x", want.x, cell_x);
                    check_field("cell_y", want.y, cell_y);
                    check_field("cell_valid", 16'(want.flags.valid), 16'(cell_valid));
                    check_field("last_cell", 16'(want.flags.last), 16'(last_cell));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        for (int phase = 0; phase < 4; phase++)
        begin
            @(posedge clk);
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 66; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 66; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            if (phase == 0)
                add_directed();
            add_random(ITEMS_PER_PHASE);
            if (phase == 0)
            begin
                wait (accepted_n >= 40);
                @(posedge clk);
                hold_req++;
            end
            wait_drained();
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && cell_expected_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
